>>> rtl/core/hsd_pkg.sv
// Shared types and constants of the Huffman stream decoder.
// No dependencies; imported by every module of the block.
package hsd_pkg;

  localparam int SYM_W        = 8;
  localparam int MAX_NODES    = 512;
  localparam int STACK_DEPTH  = 256;
  localparam int NODE_AW      = $clog2(MAX_NODES);
  localparam int NODE_CW      = $clog2(MAX_NODES + 1);
  localparam int STACK_AW     = $clog2(STACK_DEPTH);
  localparam int STACK_CW     = $clog2(STACK_DEPTH + 1);
  localparam int PEND_W       = 9;
  localparam int SBL_W        = 4;
  localparam int BIT_IDX_W    = $clog2(SYM_W);

  localparam logic [PEND_W-1:0]    PEND_MAX = '1;
  localparam logic [BIT_IDX_W-1:0] BIT_TOP  = BIT_IDX_W'(SYM_W - 1);

  typedef struct packed {
    logic [SYM_W-1:0] data_byte;
    logic             final_byte;
  } hsd_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_last;
    logic             message_end;
  } hsd_res_t;

  // One tree node as stored in the node memory.
  typedef struct packed {
    logic               leaf;
    logic [SYM_W-1:0]   sym;
    logic [NODE_AW-1:0] right;
    logic [NODE_AW-1:0] left;
  } node_t;

  // Open internal node on the build stack, with its left link once known.
  typedef struct packed {
    logic [NODE_AW-1:0] idx;
    logic [NODE_AW-1:0] left;
  } stk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_LINK,
    ST_CHECK,
    ST_FLUSH
  } hsd_state_e;

  typedef struct packed {
    logic                 load;
    logic                 bit_en;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 link_en;
    logic                 check_en;
    logic                 flush_en;
  } hsd_cmd_t;

  typedef struct packed {
    logic need_link;
    logic stop;
  } hsd_sts_t;

endpackage

>>> rtl/core/huffman_stream_decoder.sv
// Top level of the Huffman stream decoder: sequencer plus datapath.
// Depends on hsd_pkg, hsd_ctrl and hsd_dp.
//
// Use: a file is fed one byte per request on req_i (data_byte, final_byte).
// A request is taken at a rising edge with start high and busy low. Each
// file opens with a pre-order tree header; the bytes after it are decoded
// by walking that tree, one bit per cycle through the node memory.
// Decoded symbols appear on rsp_o for one cycle each, marked by valid_o;
// run_last flags the last symbol a byte produced, message_end flags the
// zero terminator of a final byte. The receiver cannot stall: every strobe
// is taken.
// Steps: a message byte keeps busy high through 8 bit steps, one step
// to settle the last node read and one to flush, then busy falls.
// A header byte adds a parent link write step per stored non-root node.
// A byte that ends the header, or hits the terminator, flushes at once.
// Each symbol waits for the next one of its byte, so the last can be
// marked; the last one shows up in the first cycle with busy low.
// Reset: asynchronous, active low; the block waits for a header. Node and
// stack memories are not cleared and are only read where written.
module huffman_stream_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  hsd_pkg::hsd_req_t req_i,
  output logic              busy,
  output logic              valid_o,
  output hsd_pkg::hsd_res_t rsp_o
);
  import hsd_pkg::*;

  hsd_cmd_t cmd;
  hsd_sts_t sts;

  hsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  hsd_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .sts_o   (sts),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

>>> rtl/core/hsd_ctrl.sv
// Sequencer of the Huffman stream decoder: one state per kind of cycle.
// Depends on hsd_pkg.
module hsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  hsd_pkg::hsd_sts_t sts_i,
  output hsd_pkg::hsd_cmd_t cmd_o,
  output logic              busy_o
);
  import hsd_pkg::*;

  hsd_state_e           state_q, state_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 last_q, last_d;
  logic                 stop_q, stop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
      last_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      last_q  <= last_d;
      stop_q  <= stop_d;
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    last_d  = last_q;
    stop_d  = stop_q;
    cmd_o   = '0;
    cmd_o.bit_idx = bit_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          bit_d      = BIT_TOP;
          state_d    = ST_BITS;
        end
      end
      ST_BITS: begin
        cmd_o.bit_en = 1'b1;
        bit_d  = bit_q - 1'b1;
        last_d = (bit_q == '0);
        stop_d = sts_i.stop;
        if (sts_i.need_link) begin
          state_d = ST_LINK;
        end else if (sts_i.stop) begin
          state_d = ST_FLUSH;
        end else if (bit_q == '0) begin
          state_d = ST_CHECK;
        end
      end
      ST_LINK: begin
        cmd_o.link_en = 1'b1;
        if (stop_q) begin
          state_d = ST_FLUSH;
        end else if (last_q) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_BITS;
        end
      end
      ST_CHECK: begin
        cmd_o.check_en = 1'b1;
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.flush_en = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> rtl/core/hsd_dp.sv
// Datapath of the Huffman stream decoder: tree build, node and stack
// memories, tree walk and one-deep result buffer. Depends on hsd_pkg.
module hsd_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsd_pkg::hsd_cmd_t cmd_i,
  input  hsd_pkg::hsd_req_t req_i,
  output hsd_pkg::hsd_sts_t sts_o,
  output logic              valid_o,
  output hsd_pkg::hsd_res_t rsp_o
);
  import hsd_pkg::*;

  // memories
  node_t node_mem [MAX_NODES];
  stk_t  stk_mem  [STACK_DEPTH];

  // payload registers
  logic [SYM_W-1:0]   byte_q;
  logic               fin_q;
  node_t              rd_q, root_q, root_d;
  stk_t               srd_q;
  stk_t               top_q, top_d;
  logic [NODE_AW-1:0] link_addr_q, link_addr_d;
  node_t              link_data_q, link_data_d;
  logic [SYM_W-1:0]   psym_q, psym_d;
  logic               pend_q, pend_d;
  hsd_res_t           out_q, out_d;

  // control registers
  logic [NODE_CW-1:0]  nodes_q, nodes_d;
  logic [STACK_CW-1:0] scnt_q, scnt_d;
  logic [PEND_W-1:0]   leaves_q, leaves_d;
  logic [SBL_W-1:0]    sbl_q, sbl_d;
  logic [SYM_W-1:0]    shift_q, shift_d;
  logic                in_msg_q, in_msg_d;
  logic                chk_q, chk_d;
  logic                use_rd_q, use_rd_d;
  logic                pop_ld_q, pop_ld_d;
  logic                pv_q, pv_d;
  logic                out_v_q, out_v_d;

  // memory ports
  logic                nwe, nrd_en, swe, srd_en;
  logic [NODE_AW-1:0]  nwaddr, nraddr;
  node_t               nwdata;
  logic [STACK_AW-1:0] swaddr, sraddr;
  stk_t                swdata;

  // scratch
  logic                bit_v, alloc, internal, popped, emit, emit_end, term;
  node_t               new_ent, cur;
  logic [NODE_AW-1:0]  idx, child;
  logic [PEND_W-1:0]   leaves_dec;
  logic [STACK_CW-1:0] scnt_pop;
  stk_t                top_n;
  logic [SYM_W-1:0]    emit_sym;

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      node_mem[nwaddr] <= nwdata;
    end
    if (nrd_en) begin
      rd_q <= node_mem[nraddr];
    end
    if (swe) begin
      stk_mem[swaddr] <= swdata;
    end
    if (srd_en) begin
      srd_q <= stk_mem[sraddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= req_i.data_byte;
      fin_q  <= req_i.final_byte;
    end
    root_q      <= root_d;
    top_q       <= top_d;
    link_addr_q <= link_addr_d;
    link_data_q <= link_data_d;
    psym_q      <= psym_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q  <= '0;
      scnt_q   <= '0;
      leaves_q <= PEND_W'(1);
      sbl_q    <= '0;
      shift_q  <= '0;
      in_msg_q <= 1'b0;
      chk_q    <= 1'b0;
      use_rd_q <= 1'b0;
      pop_ld_q <= 1'b0;
      pv_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      nodes_q  <= nodes_d;
      scnt_q   <= scnt_d;
      leaves_q <= leaves_d;
      sbl_q    <= sbl_d;
      shift_q  <= shift_d;
      in_msg_q <= in_msg_d;
      chk_q    <= chk_d;
      use_rd_q <= use_rd_d;
      pop_ld_q <= pop_ld_d;
      pv_q     <= pv_d;
      out_v_q  <= out_v_d;
    end
  end

  always_comb begin
    root_d      = root_q;
    top_d       = top_q;
    link_addr_d = link_addr_q;
    link_data_d = link_data_q;
    psym_d      = psym_q;
    pend_d      = pend_q;
    out_d       = out_q;
    nodes_d     = nodes_q;
    scnt_d      = scnt_q;
    leaves_d    = leaves_q;
    sbl_d       = sbl_q;
    shift_d     = shift_q;
    in_msg_d    = in_msg_q;
    chk_d       = chk_q;
    use_rd_d    = use_rd_q;
    pop_ld_d    = pop_ld_q;
    pv_d        = pv_q;
    out_v_d     = 1'b0;

    nwe    = 1'b0;
    nwaddr = '0;
    nwdata = '0;
    nrd_en = 1'b0;
    nraddr = '0;
    swe    = 1'b0;
    swaddr = '0;
    swdata = '0;
    srd_en = 1'b0;
    sraddr = '0;
    sts_o  = '0;

    bit_v      = byte_q[cmd_i.bit_idx];
    alloc      = 1'b0;
    internal   = 1'b0;
    popped     = 1'b0;
    new_ent    = '0;
    idx        = nodes_q[NODE_AW-1:0];
    leaves_dec = '0;
    scnt_pop   = scnt_q;
    top_n      = top_q;
    emit       = 1'b0;
    emit_end   = 1'b0;
    emit_sym   = '0;
    term       = 1'b0;
    cur        = root_q;
    child      = '0;

    // header: one tree bit per cycle, unless a parent link write holds the next
    if (cmd_i.bit_en && !in_msg_q) begin
      if (sbl_q == '0) begin
        if (bit_v) begin
          sbl_d   = SBL_W'(SYM_W);
          shift_d = '0;
        end else begin
          alloc    = 1'b1;
          internal = 1'b1;
          if (leaves_q < PEND_MAX) begin
            leaves_d = leaves_q + 1'b1;
          end
        end
      end else begin
        shift_d = {shift_q[SYM_W-2:0], bit_v};
        sbl_d   = sbl_q - 1'b1;
        if (sbl_q == SBL_W'(1)) begin
          alloc       = 1'b1;
          new_ent.leaf = 1'b1;
          new_ent.sym  = {shift_q[SYM_W-2:0], bit_v};
          leaves_dec  = (leaves_q != '0) ? leaves_q - 1'b1 : '0;
          leaves_d    = leaves_dec;
          if (leaves_dec == '0) begin
            in_msg_d   = 1'b1;
            chk_d      = 1'b0;
            use_rd_d   = 1'b0;
            sts_o.stop = 1'b1;
          end
        end
      end

      if (alloc && (nodes_q < NODE_CW'(MAX_NODES))) begin
        nwe     = 1'b1;
        nwaddr  = idx;
        nwdata  = new_ent;
        nodes_d = nodes_q + 1'b1;
        pop_ld_d = 1'b0;
        // attach to the open node on top of the stack
        if (scnt_q != '0) begin
          sts_o.need_link = 1'b1;
          link_addr_d     = top_q.idx;
          link_data_d     = '0;
          if (top_q.left == '0) begin
            link_data_d.left = idx;
            top_n.left       = idx;
          end else begin
            link_data_d.right = idx;
            link_data_d.left  = top_q.left;
            popped            = 1'b1;
          end
        end
        scnt_pop = scnt_q - STACK_CW'(popped);
        if (internal && (scnt_pop < STACK_CW'(STACK_DEPTH))) begin
          if (!popped && (scnt_q != '0)) begin
            swe    = 1'b1;
            swaddr = STACK_AW'(scnt_q - 1'b1);
            swdata = top_n;
          end
          top_d.idx  = idx;
          top_d.left = '0;
          scnt_d     = scnt_pop + 1'b1;
        end else begin
          top_d  = top_n;
          scnt_d = scnt_pop;
          if (popped && (scnt_pop != '0)) begin
            srd_en   = 1'b1;
            sraddr   = STACK_AW'(scnt_pop - 1'b1);
            pop_ld_d = 1'b1;
          end
        end
      end
    end

    // second write of an allocation: the parent's links
    if (cmd_i.link_en) begin
      nwe    = 1'b1;
      nwaddr = link_addr_q;
      nwdata = link_data_q;
      if (pop_ld_q) begin
        top_d = srd_q;
      end
    end

    // message: settle the node read last cycle, then step on this bit
    if (cmd_i.bit_en && in_msg_q && !root_q.leaf) begin
      if (chk_q && rd_q.leaf) begin
        emit     = 1'b1;
        emit_sym = rd_q.sym;
        if ((rd_q.sym == '0) && fin_q) begin
          emit_end   = 1'b1;
          term       = 1'b1;
          sts_o.stop = 1'b1;
          chk_d      = 1'b0;
          use_rd_d   = 1'b0;
        end
      end
      if (!term) begin
        cur   = ((chk_q || use_rd_q) && !rd_q.leaf) ? rd_q : root_q;
        child = bit_v ? cur.right : cur.left;
        use_rd_d = 1'b0;
        if ((child == '0) || ({1'b0, child} >= nodes_q)) begin
          chk_d = 1'b0;
        end else begin
          nrd_en = 1'b1;
          nraddr = child;
          chk_d  = 1'b1;
        end
      end
    end

    // last bit's node read of the byte
    if (cmd_i.check_en && chk_q) begin
      chk_d = 1'b0;
      if (rd_q.leaf) begin
        emit     = 1'b1;
        emit_sym = rd_q.sym;
        emit_end = (rd_q.sym == '0) && fin_q;
        use_rd_d = 1'b0;
      end else begin
        use_rd_d = 1'b1;
      end
    end

    // results leave one behind, so the last of a byte can be marked
    if (emit) begin
      if (pv_q) begin
        out_v_d           = 1'b1;
        out_d.symbol      = psym_q;
        out_d.run_last    = 1'b0;
        out_d.message_end = pend_q;
      end
      psym_d = emit_sym;
      pend_d = emit_end;
      pv_d   = 1'b1;
    end

    if (cmd_i.flush_en) begin
      if (pv_q) begin
        out_v_d           = 1'b1;
        out_d.symbol      = psym_q;
        out_d.run_last    = 1'b1;
        out_d.message_end = pend_q;
        pv_d              = 1'b0;
      end
      if (fin_q) begin
        nodes_d  = '0;
        scnt_d   = '0;
        leaves_d = PEND_W'(1);
        sbl_d    = '0;
        shift_d  = '0;
        in_msg_d = 1'b0;
        chk_d    = 1'b0;
        use_rd_d = 1'b0;
      end
    end

    if (nwe && (nwaddr == '0)) begin
      root_d = nwdata;
    end
  end

  assign valid_o = out_v_q;
  assign rsp_o   = out_q;

endmodule

>>> rtl/core/hsd_checker.sv
// Port-level checks of the Huffman stream decoder, bound to the top level.
// Depends on hsd_pkg and huffman_stream_decoder.
module hsd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              valid_o,
  input hsd_pkg::hsd_res_t rsp_o
);
  import hsd_pkg::*;

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request was taken");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.run_last) |-> !busy)
    else $error("last symbol of a byte while still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !rsp_o.run_last) |-> busy)
    else $error("non-last symbol outside of byte processing");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.message_end) |-> (rsp_o.run_last && (rsp_o.symbol == '0)))
    else $error("message end not last or with nonzero symbol");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !$past(busy)) |-> !valid_o)
    else $error("symbol while idle");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_stream_decoder: directed rows, then random files.
// Needs hsd_pkg and the decoder RTL; carries its own bit-exact predictor of the decoder.
module testbench;
  import hsd_pkg::*;

  localparam int RANDOM_ITEMS  = 100;
  // Header byte worst case: 8 bit steps, settle and flush, and a link write per node,
  // plus the wait of a symbol behind its bit.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int DIRECTED_ROWS = 22;
  localparam int MAX_DEPTH     = 10;

  // How a directed row is checked: by the predictor, no result at all, or one typed result.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    row_check_e check;
    hsd_res_t   res;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  hsd_req_t  req_i  = '0;
  logic      busy;
  logic      valid_o;
  hsd_res_t  rsp_o;

  huffman_stream_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: node memory, build stack and header/walk bookkeeping.
  // ---------------------------------------------------------------------------
  node_t              tree_mem   [MAX_NODES];
  logic [NODE_AW-1:0] open_stack [STACK_DEPTH];
  int                 open_count;
  int                 nodes_built;
  int                 leaves_due;
  int                 sym_bits_left;
  logic [7:0]         sym_acc;
  bit                 in_body;
  logic [NODE_AW-1:0] walk_at;

  // Results still owed by the decoder, oldest first.
  hsd_res_t symbols_due[$];
  int       err_count = 0;
  int       items_fed = 0;
  bit       quiet     = 1'b0;   // stretch with no sender gaps

  // Bit stream of the file under construction, MSB-first order.
  bit         stream_bits[$];
  int         leaf_code[$];
  int         leaf_len[$];
  logic [7:0] leaf_sym[$];

  function automatic void restart_header();
    nodes_built   = 0;
    open_count    = 0;
    leaves_due    = 1;
    sym_bits_left = 0;
    sym_acc       = '0;
    in_body       = 1'b0;
    walk_at       = '0;
  endfunction

  function automatic void reset_model();
    foreach (tree_mem[i]) tree_mem[i] = '0;
    foreach (open_stack[i]) open_stack[i] = '0;
    restart_header();
  endfunction

  // New node goes left of the open top if that link is empty, else right (and the
  // top closes). Past MAX_NODES nothing is stored or linked; full stack = no push.
  function automatic void add_tree_node(input node_t entry, input bit internal);
    logic [NODE_AW-1:0] idx;
    logic [NODE_AW-1:0] top;
    if (nodes_built >= MAX_NODES) return;
    idx = NODE_AW'(nodes_built);
    nodes_built++;
    tree_mem[idx] = entry;
    if (open_count > 0) begin
      top = open_stack[open_count - 1];
      if (tree_mem[top].left == '0) begin
        tree_mem[top].left = idx;
      end else begin
        tree_mem[top].right = idx;
        open_count--;
      end
    end
    if (internal && open_count < STACK_DEPTH) begin
      open_stack[open_count] = idx;
      open_count++;
    end
  endfunction

  // Symbols one file byte produces, in order, with run_last on the final one.
  function automatic void decode_model_byte(input hsd_req_t req, ref hsd_res_t got[$]);
    int                 i;
    bit                 b;
    node_t              cur;
    node_t              leaf;
    logic [NODE_AW-1:0] child;
    hsd_res_t           res;
    got.delete();
    for (i = 7; i >= 0; i--) begin
      b = req.data_byte[i];
      if (!in_body) begin
        if (sym_bits_left == 0) begin
          if (b) begin
            sym_bits_left = 8;
            sym_acc       = '0;
          end else begin
            add_tree_node('0, 1'b1);
            if (leaves_due < 511) leaves_due++;
          end
        end else begin
          sym_acc = {sym_acc[6:0], b};
          sym_bits_left--;
          if (sym_bits_left == 0) begin
            leaf      = '0;
            leaf.leaf = 1'b1;
            leaf.sym  = sym_acc;
            add_tree_node(leaf, 1'b0);
            if (leaves_due > 0) leaves_due--;
            // Header complete: rest of this byte is padding.
            if (leaves_due == 0) begin
              in_body = 1'b1;
              walk_at = '0;
              break;
            end
          end
        end
      end else if (!tree_mem[0].leaf) begin
        // Single-leaf tree never gets here, so it emits nothing.
        cur   = tree_mem[walk_at];
        child = b ? cur.right : cur.left;
        if (child == '0 || child >= nodes_built) begin
          walk_at = '0;   // unset link: back to root, silently
        end else if (!tree_mem[child].leaf) begin
          walk_at = child;
        end else begin
          walk_at         = '0;
          res.symbol      = tree_mem[child].sym;
          res.run_last    = 1'b0;
          res.message_end = 1'b0;
          if (res.symbol == '0 && req.final_byte) begin
            // Terminator in the final byte: tag it, drop the remaining bits.
            res.message_end = 1'b1;
            got.push_back(res);
            restart_header();
            break;
          end
          got.push_back(res);
        end
      end
    end
    if (req.final_byte) restart_header();
    if (got.size() > 0) begin
      res              = got[got.size() - 1];
      res.run_last     = 1'b1;
      got[got.size() - 1] = res;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got_v, want_v);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side. start stays high across back-to-back requests; it only drops
  // when a gap is drawn or results are drained, so each step sees at most one write to it.
  // ---------------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] data, input logic fin,
                           input row_check_e check = CHK_MODEL, input hsd_res_t typed = '0);
    int       gap;
    hsd_req_t req;
    hsd_res_t got[$];
    gap            = quiet ? 0 : $urandom_range(0, 19);
    req.data_byte  = data;
    req.final_byte = fin;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Taken at this edge.
    decode_model_byte(req, got);
    case (check)
      CHK_MODEL: foreach (got[k]) symbols_due.push_back(got[k]);
      CHK_ONE:   symbols_due.push_back(typed);
      default:   ;
    endcase
    items_fed++;
  endtask

  // Hold requests off until every owed symbol is out, then let a header byte finish.
  task automatic drain_results();
    start <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Pad the stream to whole bytes with random bits and send it.
  task automatic flush_stream(input bit fin_at_end);
    int         n_bytes;
    int         i;
    int         b;
    logic [7:0] byte_v;
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
    n_bytes = stream_bits.size() / 8;
    for (i = 0; i < n_bytes; i++) begin
      for (b = 0; b < 8; b++) byte_v[7 - b] = stream_bits[8 * i + b];
      feed_byte(byte_v, fin_at_end && (i == n_bytes - 1));
    end
    stream_bits.delete();
  endtask

  // Random full tree in pre-order, leaf codes kept for building messages.
  // Most trees hold a zero-symbol leaf to serve as terminator.
  function automatic void gen_tree(input int max_int);
    int pv[$];
    int pl[$];
    bit kinds[$];
    int v;
    int l;
    int n_int;
    int k;
    int i;
    leaf_code.delete();
    leaf_len.delete();
    leaf_sym.delete();
    pv.push_back(0);
    pl.push_back(0);
    n_int = 0;
    while (pv.size() > 0) begin
      v = pv.pop_back();
      l = pl.pop_back();
      if (n_int < max_int && l < MAX_DEPTH && (l == 0 || $urandom_range(0, 2) != 0)) begin
        kinds.push_back(1'b0);
        n_int++;
        pv.push_back(2 * v + 1);
        pl.push_back(l + 1);
        pv.push_back(2 * v);     // left subtree comes first
        pl.push_back(l + 1);
      end else begin
        kinds.push_back(1'b1);
        leaf_code.push_back(v);
        leaf_len.push_back(l);
        leaf_sym.push_back(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 4) != 0) leaf_sym[$urandom_range(0, leaf_sym.size() - 1)] = 8'h00;
    k = 0;
    foreach (kinds[j]) begin
      stream_bits.push_back(kinds[j]);
      if (kinds[j]) begin
        for (i = 7; i >= 0; i--) stream_bits.push_back(leaf_sym[k][i]);
        k++;
      end
    end
  endfunction

  function automatic void push_code(input int k);
    int b;
    for (b = leaf_len[k] - 1; b >= 0; b--) stream_bits.push_back(leaf_code[k][b]);
  endfunction

  // Header, random codes, then the terminator (if any) so it lands in the final byte.
  task automatic well_formed_file();
    int zero_leaf;
    gen_tree(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10));
    flush_stream(1'b0);
    repeat ($urandom_range(0, 16)) push_code($urandom_range(0, leaf_code.size() - 1));
    zero_leaf = -1;
    foreach (leaf_sym[k]) if (leaf_sym[k] == 8'h00) zero_leaf = k;
    if (zero_leaf >= 0) push_code(zero_leaf);
    if (stream_bits.size() == 0) repeat (8) stream_bits.push_back(1'($urandom_range(0, 1)));
    flush_stream(1'b1);
  endtask

  // Header cut short and closed by a final byte.
  task automatic broken_header();
    int cut;
    gen_tree($urandom_range(1, 10));
    cut = $urandom_range(1, stream_bits.size() - 1);
    stream_bits = stream_bits[0:cut-1];
    flush_stream(1'b1);
  endtask

  task automatic noise_bytes();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) feed_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Tree A: left leaf 00, right leaf FF. Tree B: single leaf AA.
  // Tree D: 01 (code 0), 80 (code 10), 00 (code 11). Header pad bits are ones.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h40, 1'b0, CHK_NONE,  '0},
    '{8'h3F, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_NONE,  '0},                   // header ends after 3 bits
    '{8'hFF, 1'b0, CHK_MODEL, '0},                   // eight FF symbols
    '{8'h00, 1'b0, CHK_MODEL, '0},                   // zero symbol as plain data
    '{8'h7F, 1'b1, CHK_ONE,   '{8'h00, 1'b1, 1'b1}}, // terminator on first bit
    '{8'hD5, 1'b0, CHK_NONE,  '0},
    '{8'h7F, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b0, CHK_NONE,  '0},                   // single leaf: silent
    '{8'h00, 1'b1, CHK_NONE,  '0},
    '{8'h00, 1'b1, CHK_NONE,  '0},                   // final header byte rearms
    '{8'h00, 1'b0, CHK_NONE,  '0},
    '{8'h00, 1'b0, CHK_NONE,  '0},
    '{8'hFF, 1'b1, CHK_NONE,  '0},                   // leaf cut by final byte
    '{8'h40, 1'b0, CHK_NONE,  '0},
    '{8'h58, 1'b0, CHK_NONE,  '0},
    '{8'h08, 1'b0, CHK_NONE,  '0},
    '{8'h07, 1'b0, CHK_NONE,  '0},
    '{8'h00, 1'b0, CHK_MODEL, '0},
    '{8'hAA, 1'b0, CHK_MODEL, '0},
    '{8'h5A, 1'b1, CHK_MODEL, '0},                   // 01, 80, then terminator
    '{8'hFF, 1'b1, CHK_NONE,  '0}
  };

  // ---------------------------------------------------------------------------
  // Result side: the receiver cannot stall, so every strobe is checked.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hsd_res_t want;
    if (rst_ni && valid_o) begin
      if (symbols_due.size() == 0) begin
        report_mismatch("symbol with none owed", rsp_o.symbol, 0);
      end else begin
        want = symbols_due.pop_front();
        if (rsp_o.symbol !== want.symbol)
          report_mismatch("symbol", rsp_o.symbol, want.symbol);
        if (rsp_o.run_last !== want.run_last)
          report_mismatch("run_last", rsp_o.run_last, want.run_last);
        if (rsp_o.message_end !== want.message_end)
          report_mismatch("message_end", rsp_o.message_end, want.message_end);
      end
    end
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int pick;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      feed_byte(directed_rows[r].data, directed_rows[r].fin,
                directed_rows[r].check, directed_rows[r].res);

    // Sender holds off until every directed symbol is out.
    drain_results();

    // Random files: mostly well formed, some cut-off headers, some noise.
    items_fed = 0;
    while (items_fed < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 7) well_formed_file();
      else if (pick < 9) broken_header();
      else noise_bytes();
    end

    drain_results();
    if (err_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
